### hw/rtl/mkcm_pkg.sv
package mkcm_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int DEBOUNCE_W = 10;
    localparam int THRESH_W   = 16;
    localparam int LENGTH_W   = 5;
    localparam int PATTERN_W  = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd50;
    localparam logic [THRESH_W-1:0]   DOT_MAX_RST  = 16'd300;
    localparam logic [THRESH_W-1:0]   GAP_RST      = 16'd2000;
    localparam logic [LENGTH_W-1:0]   LENGTH_RST   = 5'd5;
    localparam logic [PATTERN_W-1:0]  PATTERN_RST  = 16'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_DOT_MAX  = 3'd1,
        REG_GAP      = 3'd2,
        REG_LENGTH   = 3'd3,
        REG_PATTERN  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [THRESH_W-1:0]   dot_max_ticks;
        logic [THRESH_W-1:0]   gap_ticks;
        logic [LENGTH_W-1:0]   code_length;
        logic [PATTERN_W-1:0]  code_pattern;
    } cfg_t;

    typedef struct packed {
        logic key_down;
        logic symbol_valid;
        logic symbol_dash;
        logic unlock_pulse;
        logic reject_pulse;
    } result_t;

endpackage

### hw/rtl/mkcm_cfg_regs.sv
module mkcm_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mkcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mkcm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output mkcm_pkg::cfg_t                      cfg
);

    mkcm_pkg::cfg_t cfg_reg;
    mkcm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (mkcm_pkg::cfg_reg_t'(cfg_index))
                mkcm_pkg::REG_DEBOUNCE: begin
                    cfg_next.debounce_ticks = cfg_wdata[mkcm_pkg::DEBOUNCE_W-1:0];
                end
                mkcm_pkg::REG_DOT_MAX: begin
                    cfg_next.dot_max_ticks = cfg_wdata[mkcm_pkg::THRESH_W-1:0];
                end
                mkcm_pkg::REG_GAP: begin
                    cfg_next.gap_ticks = cfg_wdata[mkcm_pkg::THRESH_W-1:0];
                end
                mkcm_pkg::REG_LENGTH: begin
                    cfg_next.code_length = cfg_wdata[mkcm_pkg::LENGTH_W-1:0];
                end
                mkcm_pkg::REG_PATTERN: begin
                    cfg_next.code_pattern = cfg_wdata[mkcm_pkg::PATTERN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= mkcm_pkg::DEBOUNCE_RST;
            cfg_reg.dot_max_ticks  <= mkcm_pkg::DOT_MAX_RST;
            cfg_reg.gap_ticks      <= mkcm_pkg::GAP_RST;
            cfg_reg.code_length    <= mkcm_pkg::LENGTH_RST;
            cfg_reg.code_pattern   <= mkcm_pkg::PATTERN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/mkcm_tick_core.sv
module mkcm_tick_core #(
    parameter int MAX_SYMBOLS = mkcm_pkg::MAX_SYMBOLS_DEF,
    parameter int TIME_WIDTH  = mkcm_pkg::TIME_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tick_en,
    input  logic                key_level,
    input  mkcm_pkg::cfg_t      cfg,
    output mkcm_pkg::result_t   res
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W = $clog2(MAX_SYMBOLS);
    localparam int TCMP_W = (TIME_WIDTH > mkcm_pkg::THRESH_W) ? TIME_WIDTH
                                                               : mkcm_pkg::THRESH_W;
    localparam int LCMP_W = (CNT_W > mkcm_pkg::LENGTH_W) ? CNT_W : mkcm_pkg::LENGTH_W;
    localparam int PCMP_W = (MAX_SYMBOLS > mkcm_pkg::PATTERN_W) ? MAX_SYMBOLS
                                                                 : mkcm_pkg::PATTERN_W;

    logic                   key_pressed_reg, key_pressed_next;
    logic [TIME_WIDTH-1:0]  since_change_reg, since_change_next;
    logic [TIME_WIDTH-1:0]  press_length_reg, press_length_next;
    logic [TIME_WIDTH-1:0]  gap_length_reg, gap_length_next;
    logic                   gap_armed_reg, gap_armed_next;
    logic [MAX_SYMBOLS-1:0] symbol_bits_reg, symbol_bits_next;
    logic [CNT_W-1:0]       symbol_count_reg, symbol_count_next;
    logic                   overflowed_reg, overflowed_next;

    logic [PCMP_W-1:0]      expected_bits;
    logic                   debounce_ok;
    logic                   is_dash;
    logic                   match;

    // Only the pattern bits below the configured length take part in a match.
    always_comb begin
        for (int i = 0; i < PCMP_W; i++) begin
            if (i < mkcm_pkg::PATTERN_W && 32'(i) < 32'(cfg.code_length)) begin
                expected_bits[i] = cfg.code_pattern[i % mkcm_pkg::PATTERN_W];
            end else begin
                expected_bits[i] = 1'b0;
            end
        end
    end

    always_comb begin
        key_pressed_next  = key_pressed_reg;
        symbol_bits_next  = symbol_bits_reg;
        symbol_count_next = symbol_count_reg;
        overflowed_next   = overflowed_reg;
        gap_armed_next    = gap_armed_reg;
        res               = '0;
        is_dash           = 1'b0;
        match             = 1'b0;

        // All timers count up by one and stop at their all-ones value.
        since_change_next = (since_change_reg == '1) ? since_change_reg
                                                     : since_change_reg + 1'b1;
        press_length_next = press_length_reg;
        if (key_pressed_reg && press_length_reg != '1) begin
            press_length_next = press_length_reg + 1'b1;
        end
        gap_length_next = gap_length_reg;
        if (gap_armed_reg && gap_length_reg != '1) begin
            gap_length_next = gap_length_reg + 1'b1;
        end

        debounce_ok = TCMP_W'(since_change_next) > TCMP_W'(cfg.debounce_ticks);

        if (!key_level && !key_pressed_reg && debounce_ok) begin
            key_pressed_next  = 1'b1;
            press_length_next = '0;
            gap_armed_next    = 1'b0;
            gap_length_next   = '0;
            since_change_next = '0;
        end else if (key_level && key_pressed_reg && debounce_ok) begin
            is_dash          = TCMP_W'(press_length_next) > TCMP_W'(cfg.dot_max_ticks);
            key_pressed_next = 1'b0;
            if (symbol_count_reg < CNT_W'(MAX_SYMBOLS)) begin
                if (is_dash) begin
                    symbol_bits_next[symbol_count_reg[IDX_W-1:0]] = 1'b1;
                end
                symbol_count_next = symbol_count_reg + 1'b1;
                res.symbol_valid  = 1'b1;
                res.symbol_dash   = is_dash;
            end else begin
                overflowed_next = 1'b1;
            end
            gap_armed_next    = 1'b1;
            gap_length_next   = '0;
            since_change_next = '0;
        end

        // A release in this tick clears the gap timer, so the check cannot
        // fire on the same tick as a new symbol.
        if (gap_armed_next && TCMP_W'(gap_length_next) > TCMP_W'(cfg.gap_ticks)) begin
            match = !overflowed_next
                    && LCMP_W'(symbol_count_next) == LCMP_W'(cfg.code_length)
                    && PCMP_W'(symbol_bits_next) == expected_bits;
            res.unlock_pulse  = match;
            res.reject_pulse  = !match;
            symbol_bits_next  = '0;
            symbol_count_next = '0;
            overflowed_next   = 1'b0;
            gap_armed_next    = 1'b0;
            gap_length_next   = '0;
        end

        res.key_down = key_pressed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pressed_reg  <= 1'b0;
            since_change_reg <= '0;
            press_length_reg <= '0;
            gap_length_reg   <= '0;
            gap_armed_reg    <= 1'b0;
            symbol_bits_reg  <= '0;
            symbol_count_reg <= '0;
            overflowed_reg   <= 1'b0;
        end else if (tick_en) begin
            key_pressed_reg  <= key_pressed_next;
            since_change_reg <= since_change_next;
            press_length_reg <= press_length_next;
            gap_length_reg   <= gap_length_next;
            gap_armed_reg    <= gap_armed_next;
            symbol_bits_reg  <= symbol_bits_next;
            symbol_count_reg <= symbol_count_next;
            overflowed_reg   <= overflowed_next;
        end
    end

endmodule

### hw/rtl/morse_key_code_matcher_unit.sv
// Morse key matcher: each accepted request is one timer tick carrying the raw
// active-low key level, and each produces exactly one result with the debounced
// key state, any symbol appended, and the unlock or reject pulse of a finished
// entry. Requests are taken at one per clock cycle unless results back up;
// each request waits in the input register until the tick logic loads its
// result into the result register, from which it is presented. Back-pressure
// on the result side stalls the input side once both registers are full.
// Configuration registers (debounce, dot limit, gap, code length, code pattern)
// are written by index through the cfg port and should only be changed while
// idle.
module morse_key_code_matcher_unit #(
    parameter int MAX_SYMBOLS = mkcm_pkg::MAX_SYMBOLS_DEF,
    parameter int TIME_WIDTH  = mkcm_pkg::TIME_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_key_level,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_key_down,
    output logic                                m_symbol_valid,
    output logic                                m_symbol_dash,
    output logic                                m_unlock_pulse,
    output logic                                m_reject_pulse,

    input  logic                                cfg_wr_en,
    input  logic [mkcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mkcm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    mkcm_pkg::cfg_t     cfg;
    mkcm_pkg::result_t  tick_res;
    mkcm_pkg::result_t  result_reg;

    logic in_valid_reg;
    logic level_reg;
    logic out_valid_reg;
    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    mkcm_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mkcm_tick_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_tick_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_en   (advance),
        .key_level (level_reg),
        .cfg       (cfg),
        .res       (tick_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            level_reg <= s_key_level;
        end
        if (advance) begin
            result_reg <= tick_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_key_down     = result_reg.key_down;
    assign m_symbol_valid = result_reg.symbol_valid;
    assign m_symbol_dash  = result_reg.symbol_dash;
    assign m_unlock_pulse = result_reg.unlock_pulse;
    assign m_reject_pulse = result_reg.reject_pulse;

endmodule
